/* sv/asmp_pkg.sv */
// Shared types and constants for the all-pairs shortest path block.
// No dependencies; imported by every module of the block but asmp_mem.
package asmp_pkg;

    localparam int DEF_MAX_NODES = 64;
    localparam int DEF_COST_BITS = 16;

    localparam int ACTION_W = 2;
    localparam int NODE_W   = 6;
    localparam int COST_W   = 16;
    localparam int DIST_W   = 16;
    localparam int CNT_W    = 7;

    localparam logic [CNT_W-1:0] NODE_COUNT_RST = 7'd64;

    localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_RUN   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_READ  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROW,
        ST_STREAM,
        ST_DRAIN
    } t_state;

endpackage

/* sv/asmp_mem.sv */
// Distance matrix store: one write port, two read ports, registered read data.
// Depends on nothing; instantiated by the top level.
module asmp_mem #(
    parameter int AW = 12,
    parameter int DW = 16
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr_a,
    input  logic [AW-1:0] i_raddr_b,
    output logic [DW-1:0] o_rdata_a,
    output logic [DW-1:0] o_rdata_b
);

    logic [DW-1:0] r_mem [0:(1<<AW)-1];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read-before-write on a same-address collision
    always_ff @(posedge i_clk) begin
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

/* sv/asmp_seq.sv */
// Closure sequencer: walks k, i, j and relaxes one entry per cycle in ST_STREAM.
// Depends on asmp_pkg; drives the read and write ports of asmp_mem.
module asmp_seq #(
    parameter int  MAX_NODES = 64,
    parameter int  COST_BITS = 16,
    localparam int IDX       = $clog2(MAX_NODES),
    localparam int CW        = (IDX + 1 > asmp_pkg::CNT_W) ? IDX + 1 : asmp_pkg::CNT_W
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [CW-1:0]        i_nodes,
    input  logic [COST_BITS-1:0] i_rdata_a,
    input  logic [COST_BITS-1:0] i_rdata_b,
    output logic                 o_busy,
    output logic [2*IDX-1:0]     o_raddr_a,
    output logic [2*IDX-1:0]     o_raddr_b,
    output logic                 o_we,
    output logic [2*IDX-1:0]     o_waddr,
    output logic [COST_BITS-1:0] o_wdata
);
    import asmp_pkg::*;

    t_state               r_state, n_state;
    logic [IDX-1:0]       r_k, r_i, r_j, n_k, n_i, n_j;
    logic [COST_BITS-1:0] r_dik;
    logic                 r_dik_ld;
    logic                 r_s1_valid;
    logic [2*IDX-1:0]     r_s1_addr;
    logic                 k_last, i_last, j_last;
    logic [COST_BITS:0]   through;

    assign k_last = (CW'(r_k) == i_nodes - CW'(1));
    assign i_last = (CW'(r_i) == i_nodes - CW'(1));
    assign j_last = (CW'(r_j) == i_nodes - CW'(1));

    // next state and loop counters
    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_i     = r_i;
        n_j     = r_j;
        case (r_state)
            ST_IDLE: begin
                if (i_start && (i_nodes != '0)) begin
                    n_state = ST_ROW;
                    n_k     = '0;
                    n_i     = '0;
                    n_j     = '0;
                end
            end
            ST_ROW: begin
                n_state = ST_STREAM;
                n_j     = '0;
            end
            ST_STREAM: begin
                if (j_last) begin
                    n_j = '0;
                    if (i_last) begin
                        n_i = '0;
                        if (k_last) begin
                            n_state = ST_DRAIN;
                        end else begin
                            n_k     = r_k + IDX'(1);
                            n_state = ST_ROW;
                        end
                    end else begin
                        n_i     = r_i + IDX'(1);
                        n_state = ST_ROW;
                    end
                end else begin
                    n_j = r_j + IDX'(1);
                end
            end
            ST_DRAIN: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // read addresses: d[i][k] once per row, then d[i][j] and d[k][j] per column
    always_comb begin
        o_busy    = (r_state != ST_IDLE);
        o_raddr_a = {r_i, r_j};
        o_raddr_b = {r_k, r_j};
        case (r_state)
            ST_ROW:  o_raddr_a = {r_i, r_k};
            default: o_raddr_a = {r_i, r_j};
        endcase
    end

    // row k and column k never change during pass k, so no interlock is needed
    assign through = (COST_BITS+1)'(r_dik) + (COST_BITS+1)'(i_rdata_b);
    assign o_we    = r_s1_valid && (through < {1'b0, i_rdata_a});
    assign o_waddr = r_s1_addr;
    assign o_wdata = through[COST_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_k        <= '0;
            r_i        <= '0;
            r_j        <= '0;
            r_dik_ld   <= 1'b0;
            r_s1_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_k        <= n_k;
            r_i        <= n_i;
            r_j        <= n_j;
            r_dik_ld   <= (r_state == ST_ROW);
            r_s1_valid <= (r_state == ST_STREAM);
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_addr <= {r_i, r_j};
        if (r_dik_ld) begin
            r_dik <= i_rdata_a;
        end
    end

endmodule

/* sv/all_pairs_shortest_paths.sv */
// All-pairs shortest path (Floyd-Warshall) over a matrix held in a dual-read memory.
// A read's distance passes through the memory's read register into a two-entry
// result queue, pushed while r_rd_pend is set. A run with a nonzero node count keeps
// the input stalled while it walks all n*n*n relaxations (n = node count capped at
// MAX_NODES): one relaxation per cycle plus one d[i][k] fetch per row.
// Synchronous active-low reset clears control state and sets node_count to 64.
module all_pairs_shortest_paths #(
    parameter int MAX_NODES = asmp_pkg::DEF_MAX_NODES,
    parameter int COST_BITS = asmp_pkg::DEF_COST_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [asmp_pkg::CNT_W-1:0]    i_cfg_node_count,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [asmp_pkg::ACTION_W-1:0] i_action,
    input  logic [asmp_pkg::NODE_W-1:0]   i_row,
    input  logic [asmp_pkg::NODE_W-1:0]   i_col,
    input  logic [asmp_pkg::COST_W-1:0]   i_cost,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [asmp_pkg::DIST_W-1:0]   o_distance
);
    import asmp_pkg::*;

    localparam int IDX = $clog2(MAX_NODES);
    localparam int AW  = 2 * IDX;
    localparam int CW  = (IDX + 1 > CNT_W) ? IDX + 1 : CNT_W;
    localparam int RW  = ((IDX > NODE_W) ? IDX : NODE_W) + 1;
    localparam int CE  = (COST_BITS > COST_W) ? COST_BITS : COST_W;

    logic [CNT_W-1:0]     r_node_count;
    logic [CW-1:0]        ncfg_ext, n_eff;
    logic [RW-1:0]        row_ext, col_ext;
    logic                 in_range;
    logic [AW-1:0]        host_addr;
    logic [CE-1:0]        cost_ext, q_ext;
    logic                 in_fire, pop, push, credit_ok;
    logic                 host_we, host_rd, start;
    logic [2:0]           occ;

    logic                 seq_busy, seq_we;
    logic [AW-1:0]        seq_raddr_a, seq_raddr_b, seq_waddr;
    logic [COST_BITS-1:0] seq_wdata;

    logic                 mem_we;
    logic [AW-1:0]        mem_waddr, mem_raddr_a;
    logic [COST_BITS-1:0] mem_wdata, mem_q_a, mem_q_b;

    logic                 r_rd_pend, r_rd_zero;
    logic [DIST_W-1:0]    r_q [0:1];
    logic [1:0]           r_cnt;
    logic                 r_rp, r_wp;

    // configuration
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= NODE_COUNT_RST;
        end else if (i_cfg_valid) begin
            r_node_count <= i_cfg_node_count;
        end
    end

    assign ncfg_ext = CW'(r_node_count);
    assign n_eff    = (ncfg_ext > CW'(MAX_NODES)) ? CW'(MAX_NODES) : ncfg_ext;

    // host side decode
    assign row_ext   = RW'(i_row);
    assign col_ext   = RW'(i_col);
    assign in_range  = (row_ext < RW'(MAX_NODES)) && (col_ext < RW'(MAX_NODES));
    assign host_addr = {row_ext[IDX-1:0], col_ext[IDX-1:0]};
    assign cost_ext  = CE'(i_cost);

    assign pop       = o_out_valid && i_out_ready;
    assign occ       = 3'(r_cnt) + 3'(r_rd_pend) - 3'(pop);
    assign credit_ok = (occ < 3'd2);
    assign o_in_ready = !seq_busy && credit_ok;
    assign in_fire   = i_in_valid && o_in_ready;

    always_comb begin
        host_we = 1'b0;
        host_rd = 1'b0;
        start   = 1'b0;
        case (i_action)
            ACT_WRITE: host_we = in_fire && in_range;
            ACT_RUN:   start   = in_fire;
            ACT_READ:  host_rd = in_fire;
            default:   host_we = 1'b0;
        endcase
    end

    asmp_seq #(
        .MAX_NODES (MAX_NODES),
        .COST_BITS (COST_BITS)
    ) u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_nodes   (n_eff),
        .i_rdata_a (mem_q_a),
        .i_rdata_b (mem_q_b),
        .o_busy    (seq_busy),
        .o_raddr_a (seq_raddr_a),
        .o_raddr_b (seq_raddr_b),
        .o_we      (seq_we),
        .o_waddr   (seq_waddr),
        .o_wdata   (seq_wdata)
    );

    // the host only gets the ports while the sequencer is idle
    assign mem_we      = seq_we || host_we;
    assign mem_waddr   = seq_we ? seq_waddr : host_addr;
    assign mem_wdata   = seq_we ? seq_wdata : cost_ext[COST_BITS-1:0];
    assign mem_raddr_a = seq_busy ? seq_raddr_a : host_addr;

    asmp_mem #(
        .AW (AW),
        .DW (COST_BITS)
    ) u_mem (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_waddr   (mem_waddr),
        .i_wdata   (mem_wdata),
        .i_raddr_a (mem_raddr_a),
        .i_raddr_b (seq_raddr_b),
        .o_rdata_a (mem_q_a),
        .o_rdata_b (mem_q_b)
    );

    // result queue
    assign q_ext       = CE'(mem_q_a);
    assign push        = r_rd_pend;
    assign o_out_valid = (r_cnt != 2'd0);
    assign o_distance  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_pend <= 1'b0;
            r_cnt     <= 2'd0;
            r_rp      <= 1'b0;
            r_wp      <= 1'b0;
        end else begin
            r_rd_pend <= host_rd;
            r_cnt     <= r_cnt + 2'(push) - 2'(pop);
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_zero <= !in_range;
        if (push) begin
            r_q[r_wp] <= r_rd_zero ? '0 : q_ext[DIST_W-1:0];
        end
    end

endmodule

/* sv/asmp_chk.sv */
// Port-level checker for all_pairs_shortest_paths, bound to the top level.
// Depends on asmp_pkg for the action codes.
module asmp_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_cfg_valid,
    input logic                          o_cfg_ready,
    input logic [asmp_pkg::CNT_W-1:0]    i_cfg_node_count,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic [asmp_pkg::ACTION_W-1:0] i_action,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [asmp_pkg::DIST_W-1:0]   o_distance
);
    import asmp_pkg::*;

    logic r_cfg_zero;
    logic in_fire;

    assign in_fire = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_zero <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_cfg_zero <= (i_cfg_node_count == '0);
        end
    end

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_distance))
        else $error("result dropped or changed while stalled");

    a_read_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && (i_action == ACT_READ) && !o_out_valid |=> ##1 o_out_valid)
        else $error("read transaction gave no result");

    a_run_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && (i_action == ACT_RUN) && !r_cfg_zero && !(i_cfg_valid && o_cfg_ready)
        |=> !o_in_ready)
        else $error("input not stalled during closure run");

endmodule

bind all_pairs_shortest_paths asmp_chk u_asmp_chk (.*);

/* tb/sv/distance_scoreboard.sv */
// Scoreboard for the all-pairs shortest path testbench: keeps its own copy of the
// distance matrix and node count, queues expected read distances and checks results.
// Depends on asmp_pkg.
class distance_scoreboard;
    bit [asmp_pkg::COST_W-1:0] dist_q [asmp_pkg::DEF_MAX_NODES][asmp_pkg::DEF_MAX_NODES];
    bit [asmp_pkg::CNT_W-1:0]  node_cnt;
    bit [asmp_pkg::DIST_W-1:0] expected_dist [$];
    int                        errors;

    function new();
        node_cnt = asmp_pkg::NODE_COUNT_RST;
        errors   = 0;
    endfunction

    function int pending();
        return expected_dist.size();
    endfunction

    // Called for every accepted input transaction.
    function void note_item(logic [asmp_pkg::ACTION_W-1:0] action,
                            logic [asmp_pkg::NODE_W-1:0] row,
                            logic [asmp_pkg::NODE_W-1:0] col,
                            logic [asmp_pkg::COST_W-1:0] cost);
        int n, k, i, j;
        bit [asmp_pkg::COST_W:0] through;
        case (action)
            asmp_pkg::ACT_WRITE: dist_q[row][col] = cost;
            asmp_pkg::ACT_RUN: begin
                n = (node_cnt > asmp_pkg::DEF_MAX_NODES) ? asmp_pkg::DEF_MAX_NODES
                                                          : int'(node_cnt);
                for (k = 0; k < n; k++) begin
                    for (i = 0; i < n; i++) begin
                        for (j = 0; j < n; j++) begin
                            // one bit wider: two large costs never wrap
                            through = {1'b0, dist_q[i][k]} + {1'b0, dist_q[k][j]};
                            if ({1'b0, dist_q[i][j]} > through)
                                dist_q[i][j] = through[asmp_pkg::COST_W-1:0];
                        end
                    end
                end
            end
            asmp_pkg::ACT_READ: expected_dist.push_back(dist_q[row][col]);
            default: ;  // unused action is dropped by the block
        endcase
    endfunction

    function void check_distance(logic [asmp_pkg::DIST_W-1:0] got);
        bit [asmp_pkg::DIST_W-1:0] want;
        if (expected_dist.size() == 0) begin
            $error("distance: no read outstanding, actual %0d", got);
            errors++;
            return;
        end
        want = expected_dist.pop_front();
        if (got !== want) begin
            $error("distance: expected %0d, actual %0d", want, got);
            errors++;
        end
    endfunction
endclass

/* tb/sv/all_pairs_shortest_paths_tb.sv */
// Top-level testbench for all_pairs_shortest_paths: directed and random matrix
// loads, closure runs and reads, with random stalls on both handshake sides.
// Depends on asmp_pkg, distance_scoreboard.sv and the block's RTL.
module all_pairs_shortest_paths_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import asmp_pkg::*;

    localparam int NODES        = DEF_MAX_NODES;
    localparam int ITEMS        = 400;
    localparam int DRAIN_CYCLES = 8;
    localparam int LONG_HOLD    = 400;
    localparam int CYCLE_LIMIT  = 4_000_000;

    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [CNT_W-1:0]    i_cfg_node_count;
    logic                i_in_valid;
    logic                o_in_ready;
    logic [ACTION_W-1:0] i_action;
    logic [NODE_W-1:0]   i_row;
    logic [NODE_W-1:0]   i_col;
    logic [COST_W-1:0]   i_cost;
    logic                o_out_valid;
    logic                i_out_ready;
    logic [DIST_W-1:0]   o_distance;

    distance_scoreboard sb = new();

    bit          written [NODES][NODES];
    int          phase_nodes;
    bit          gaps_on;
    int          random_ops      = 0;
    int          long_holds_req  = 0;
    int unsigned cycle_count     = 0;

    all_pairs_shortest_paths dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Transaction monitors; values sampled here are the pre-edge ones.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                sb.node_cnt = i_cfg_node_count;
            if (i_in_valid && o_in_ready)
                sb.note_item(i_action, i_row, i_col, i_cost);
            if (o_out_valid && i_out_ready)
                sb.check_distance(o_distance);
        end
    end

    // Result sink: short and long stalls, calm stretches, and long holds on request.
    initial begin : sink
        int hold_left, calm_left, holds_done, r;
        hold_left  = 0;
        calm_left  = 0;
        holds_done = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_holds_req > holds_done) begin
                holds_done++;
                hold_left = LONG_HOLD;
            end else if (hold_left == 0 && calm_left == 0) begin
                r = $urandom_range(0, 99);
                if (r < 3)
                    calm_left = $urandom_range(50, 300);
                else if (r < 25)
                    hold_left = $urandom_range(1, 3);
                else if (r < 28)
                    hold_left = $urandom_range(10, 40);
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                if (calm_left > 0)
                    calm_left--;
                i_out_ready <= 1'b1;
            end
        end
    end

    function automatic int gap_len();
        int r;
        if (!gaps_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [NODE_W-1:0] rand_node(int limit);
        return NODE_W'($urandom_range(0, limit - 1));
    endfunction

    // Mix of absent edges, zero costs, short hops and fully random costs.
    function automatic logic [COST_W-1:0] pick_cost();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return '1;
        if (r < 25)
            return '0;
        if (r < 55)
            return COST_W'($urandom_range(1, 64));
        return COST_W'($urandom_range(0, 16'hFFFF));
    endfunction

    // Returns at the edge where the transaction is accepted; valid stays high.
    task automatic send_item(input logic [ACTION_W-1:0] action, input logic [NODE_W-1:0] row,
                             input logic [NODE_W-1:0] col, input logic [COST_W-1:0] cost);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action   <= action;
        i_row      <= row;
        i_col      <= col;
        i_cost     <= cost;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic send_write(input logic [NODE_W-1:0] row, input logic [NODE_W-1:0] col,
                              input logic [COST_W-1:0] cost);
        written[row][col] = 1'b1;
        send_item(ACT_WRITE, row, col, cost);
    endtask

    task automatic send_read(input logic [NODE_W-1:0] row, input logic [NODE_W-1:0] col);
        send_item(ACT_READ, row, col, pick_cost());
    endtask

    // Mostly inside the node count; reads only land on written entries.
    task automatic pick_entry(output logic [NODE_W-1:0] row, output logic [NODE_W-1:0] col,
                              input bit readable);
        if ($urandom_range(0, 9) < 7) begin
            row = rand_node(phase_nodes);
            col = rand_node(phase_nodes);
        end else begin
            row = rand_node(NODES);
            col = rand_node(NODES);
            if (readable && !written[row][col]) begin
                row = rand_node(phase_nodes);
                col = rand_node(phase_nodes);
            end
        end
    endtask

    // Every phase ends on a read, so once it returns any run before it is done.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_node_count(input logic [CNT_W-1:0] value);
        wait_idle();
        i_cfg_valid      <= 1'b1;
        i_cfg_node_count <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        phase_nodes = (value > NODES) ? NODES : int'(value);
    endtask

    // Load whatever is unwritten inside the count, then a random mix of transactions.
    // A big phase makes exactly one closure run, right after the load.
    task automatic run_phase(input logic [CNT_W-1:0] count, input bit big);
        int i, j, ops, r;
        logic [NODE_W-1:0] row, col;
        set_node_count(count);
        gaps_on = ($urandom_range(0, 3) != 0);
        for (i = 0; i < phase_nodes; i++)
            for (j = 0; j < phase_nodes; j++)
                if (!written[i][j])
                    send_write(NODE_W'(i), NODE_W'(j), pick_cost());
        if (big)
            send_item(ACT_RUN, rand_node(NODES), rand_node(NODES), pick_cost());
        ops = big ? 30 : $urandom_range(15, 40);
        repeat (ops) begin
            r = $urandom_range(0, 99);
            if (r < 40) begin
                pick_entry(row, col, 1'b0);
                send_write(row, col, pick_cost());
            end else if (r < 82 || (big && r < 97)) begin
                pick_entry(row, col, 1'b1);
                send_read(row, col);
            end else if (r < 97) begin
                send_item(ACT_RUN, rand_node(NODES), rand_node(NODES), pick_cost());
            end else begin
                send_item(ACT_UNUSED, rand_node(NODES), rand_node(NODES), pick_cost());
            end
            if (r < 97)
                random_ops++;
        end
        pick_entry(row, col, 1'b1);
        send_read(row, col);
    endtask

    initial begin
        i_rst_n          <= 1'b0;
        i_cfg_valid      <= 1'b0;
        i_cfg_node_count <= NODE_COUNT_RST;
        i_in_valid       <= 1'b0;
        i_action         <= ACT_WRITE;
        i_row            <= '0;
        i_col            <= '0;
        i_cost           <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Three nodes: 0->1 costs 4, 2->0 costs 3, self-loops cost 0, all else absent.
        // The absent pairs sum past 16 bits and must not replace anything.
        set_node_count(7'd3);
        gaps_on = 1'b1;
        send_write(6'd0, 6'd0, 16'd0);
        send_write(6'd0, 6'd1, 16'd4);
        send_write(6'd0, 6'd2, 16'hFFFF);
        send_write(6'd1, 6'd0, 16'hFFFF);
        send_write(6'd1, 6'd1, 16'd0);
        send_write(6'd1, 6'd2, 16'hFFFF);
        send_write(6'd2, 6'd0, 16'd3);
        send_write(6'd2, 6'd1, 16'hFFFF);
        send_write(6'd2, 6'd2, 16'd0);
        // outside the node count: stored, untouched by the run
        send_write(6'd63, 6'd63, 16'hA5A5);
        send_write(6'd63, 6'd0, 16'h5A5A);
        send_item(ACT_UNUSED, 6'd0, 6'd0, 16'h1234);
        send_item(ACT_RUN, 6'd63, 6'd63, 16'hFFFF);
        send_read(6'd2, 6'd1);
        send_read(6'd1, 6'd2);
        send_read(6'd0, 6'd0);
        send_read(6'd63, 6'd63);
        send_read(6'd63, 6'd0);
        // zero nodes: a run leaves the matrix alone
        set_node_count(7'd0);
        send_write(6'd2, 6'd1, 16'hFFFF);
        send_item(ACT_RUN, 6'd0, 6'd0, 16'd0);
        send_read(6'd2, 6'd1);

        run_phase(7'd64, 1'b1);

        // Back-to-back reads against a long sink hold fill the result queue.
        gaps_on = 1'b0;
        long_holds_req++;
        repeat (24) send_read(rand_node(NODES), rand_node(NODES));

        run_phase(7'd1, 1'b0);
        while (random_ops < ITEMS)
            run_phase(CNT_W'(($urandom_range(0, 4) == 0) ? $urandom_range(9, 12)
                                                         : $urandom_range(1, 8)), 1'b0);
        run_phase(7'd127, 1'b1);

        wait_idle();
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
